[src/crtm_pkg.sv]
// shared types and constants for the clock rate table match block
package crtm_pkg;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 5;

  localparam logic [CFG_AW-1:0] REG_TABLE_COUNT  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_PARENT_COUNT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_MATCH_EXACT  = 2'd2;

  localparam logic [1:0] FUNC_TABLE = 2'd0;
  localparam logic [1:0] FUNC_PMAP  = 2'd1;
  localparam logic [1:0] FUNC_RATE  = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EMPTY       = 3'd1;
  localparam logic [2:0] ST_ZERO_REQ    = 3'd2;
  localparam logic [2:0] ST_NOT_EXACT   = 3'd3;
  localparam logic [2:0] ST_ZERO_FREQ   = 3'd4;
  localparam logic [2:0] ST_UNMAPPED    = 3'd5;
  localparam logic [2:0] ST_ZERO_PREDIV = 3'd6;

  localparam int SEL_LSB = 8;
  localparam int SEL_W   = 3;
  localparam int HID_W   = 5;

  localparam int DIV_W   = 33;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TWAIT,
    S_TLAT,
    S_DIV1,
    S_DIV2,
    S_NEXT,
    S_CHK,
    S_BWAIT,
    S_BLAT,
    S_PWAIT,
    S_PCMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  entry_index;
    logic [31:0] freq_hz;
    logic [7:0]  parent_ref;
    logic [5:0]  pre_div;
    logic [15:0] m_value;
    logic [15:0] n_value;
    logic [2:0]  source_select;
    logic [31:0] req_hz;
    logic [31:0] cur_cfg;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  best_index;
    logic [31:0] src_hz;
    logic [31:0] cfg_word;
    logic [15:0] m_out;
    logic [15:0] n_out;
    logic [15:0] d_out;
  } res_t;

  typedef struct packed {
    logic [31:0] freq;
    logic [7:0]  parent;
    logic [5:0]  prediv;
    logic [15:0] m;
    logic [15:0] n;
  } entry_t;

  typedef struct packed {
    logic [7:0]       id;
    logic [SEL_W-1:0] sel;
  } pmap_t;

  localparam int ENTRY_W = $bits(entry_t);
  localparam int PMAP_W  = $bits(pmap_t);

endpackage

[src/crtm_if.sv]
// request and result channel interfaces
interface crtm_req_if;
  logic            valid;
  logic            ready;
  crtm_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface crtm_res_if;
  logic            valid;
  logic            ready;
  crtm_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/crtm_ram.sv]
// generic single-write, single-read ram with registered read data
module crtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/crtm_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module crtm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [crtm_pkg::DIV_W-1:0] dividend,
  input  logic [crtm_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [crtm_pkg::DIV_W-1:0] quot
);

  logic                           run;
  logic [crtm_pkg::DIV_CNT_W-1:0] cnt;
  logic [crtm_pkg::DIV_W-1:0]     rem;
  logic [crtm_pkg::DIV_W-1:0]     dsr;
  logic [crtm_pkg::DIV_W:0]       shifted;
  logic [crtm_pkg::DIV_W:0]       diff;

  assign shifted = {rem, quot[crtm_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= crtm_pkg::DIV_CNT_W'(crtm_pkg::DIV_W);
      end else if (run) begin
        cnt <= cnt - crtm_pkg::DIV_CNT_W'(1);
        if (cnt == crtm_pkg::DIV_CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dsr  <= divisor;
    end else if (run) begin
      if (!diff[crtm_pkg::DIV_W]) begin
        rem  <= diff[crtm_pkg::DIV_W-1:0];
        quot <= {quot[crtm_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[crtm_pkg::DIV_W-1:0];
        quot <= {quot[crtm_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

[src/clock_rate_table_match.sv]
// top level: frequency table search and divider word builder
// loads and parent map writes go straight into their rams; a rate request walks the table entries in use
// a nonzero entry takes a table read and two serial divides, a zero entry skips the divides
// then the winner is read back and the parent map is searched one entry at a time
// one request at a time; the result register lets the next request be taken while it waits
// synchronous reset clears control and the config registers; table contents stay undefined until loaded
module clock_rate_table_match #(
  parameter int TABLE_DEPTH = 16,
  parameter int PMAP_DEPTH  = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [crtm_pkg::CFG_AW-1:0] cfg_index,
  input  logic [crtm_pkg::CFG_DW-1:0] cfg_data,
  crtm_req_if.sink                    request,
  crtm_res_if.source                  result
);

  localparam int IW  = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int PW  = PMAP_DEPTH > 1 ? $clog2(PMAP_DEPTH) : 1;
  localparam int PCW = $clog2(PMAP_DEPTH + 1);

  crtm_pkg::state_t state, state_next;

  logic [4:0] table_count;
  logic [3:0] parent_count;
  logic       match_exact;

  logic [CW-1:0]  count;
  logic [PCW-1:0] pcount;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  idx_next;
  logic [PCW-1:0] pidx;
  logic [PCW-1:0] pidx_next;
  logic [IW-1:0]  win_idx;
  logic [31:0]    win_delta;
  logic [31:0]    rq_hz;
  logic [31:0]    cur;
  logic [2:0]     status;
  logic [crtm_pkg::SEL_W-1:0] sel;
  crtm_pkg::entry_t ent;

  logic             accept;
  logic             tbl_we;
  logic             pm_we;
  crtm_pkg::entry_t tbl_wdata;
  crtm_pkg::entry_t tbl_rdata;
  crtm_pkg::pmap_t  pm_wdata;
  crtm_pkg::pmap_t  pm_rdata;

  logic                       div_start;
  logic                       div_done;
  logic [crtm_pkg::DIV_W-1:0] div_dividend;
  logic [crtm_pkg::DIV_W-1:0] div_divisor;
  logic [crtm_pkg::DIV_W-1:0] div_quot;
  logic [31:0]                delta;

  logic           res_load;
  crtm_pkg::res_t res_next;
  logic [15:0]    d_val;
  logic [31:0]    cfg_val;
  logic [5:0]     hid_full;

  assign count  = (9'(table_count) > 9'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(table_count);
  assign pcount = (7'(parent_count) > 7'(PMAP_DEPTH)) ? PCW'(PMAP_DEPTH) : PCW'(parent_count);
  assign idx_next  = idx + CW'(1);
  assign pidx_next = pidx + PCW'(1);
  assign accept = request.valid && request.ready;
  assign delta  = rq_hz - div_quot[31:0];

  assign tbl_wdata = '{freq:   request.data.freq_hz,
                       parent: request.data.parent_ref,
                       prediv: request.data.pre_div,
                       m:      request.data.m_value,
                       n:      request.data.n_value};
  assign pm_wdata  = '{id: request.data.parent_ref, sel: request.data.source_select};

  crtm_ram #(.WIDTH(crtm_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IW'(request.data.entry_index)),
    .wdata (tbl_wdata),
    .raddr (idx[IW-1:0]),
    .rdata (tbl_rdata)
  );

  crtm_ram #(.WIDTH(crtm_pkg::PMAP_W), .DEPTH(PMAP_DEPTH)) u_pmap (
    .clk   (clk),
    .we    (pm_we),
    .waddr (PW'(request.data.entry_index)),
    .wdata (pm_wdata),
    .raddr (pidx[PW-1:0]),
    .rdata (pm_rdata)
  );

  crtm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      crtm_pkg::S_IDLE: begin
        if (accept && request.data.func == crtm_pkg::FUNC_RATE) begin
          if (count == '0 || request.data.req_hz == '0) begin
            state_next = crtm_pkg::S_DONE;
          end else begin
            state_next = crtm_pkg::S_TWAIT;
          end
        end
      end
      crtm_pkg::S_TWAIT: state_next = crtm_pkg::S_TLAT;
      crtm_pkg::S_TLAT: begin
        state_next = (tbl_rdata.freq == '0) ? crtm_pkg::S_NEXT : crtm_pkg::S_DIV1;
      end
      crtm_pkg::S_DIV1: begin
        if (div_done) begin
          state_next = crtm_pkg::S_DIV2;
        end
      end
      crtm_pkg::S_DIV2: begin
        if (div_done) begin
          state_next = crtm_pkg::S_NEXT;
        end
      end
      crtm_pkg::S_NEXT: begin
        state_next = (idx_next == count) ? crtm_pkg::S_CHK : crtm_pkg::S_TWAIT;
      end
      crtm_pkg::S_CHK: begin
        if (match_exact && win_delta != '0) begin
          state_next = crtm_pkg::S_DONE;
        end else begin
          state_next = crtm_pkg::S_BWAIT;
        end
      end
      crtm_pkg::S_BWAIT: state_next = crtm_pkg::S_BLAT;
      crtm_pkg::S_BLAT: begin
        if (tbl_rdata.freq == '0 || pcount == '0) begin
          state_next = crtm_pkg::S_DONE;
        end else begin
          state_next = crtm_pkg::S_PWAIT;
        end
      end
      crtm_pkg::S_PWAIT: state_next = crtm_pkg::S_PCMP;
      crtm_pkg::S_PCMP: begin
        if (pm_rdata.id == ent.parent || pidx_next == pcount) begin
          state_next = crtm_pkg::S_DONE;
        end else begin
          state_next = crtm_pkg::S_PWAIT;
        end
      end
      crtm_pkg::S_DONE: begin
        if (!result.valid || result.ready) begin
          state_next = crtm_pkg::S_IDLE;
        end
      end
      default: state_next = crtm_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    request.ready = 1'b0;
    tbl_we        = 1'b0;
    pm_we         = 1'b0;
    div_start     = 1'b0;
    div_dividend  = {1'b0, tbl_rdata.freq} + {1'b0, rq_hz} - crtm_pkg::DIV_W'(1);
    div_divisor   = {1'b0, rq_hz};
    res_load      = 1'b0;
    case (state)
      crtm_pkg::S_IDLE: begin
        request.ready = 1'b1;
        tbl_we = request.valid && request.data.func == crtm_pkg::FUNC_TABLE &&
                 9'(request.data.entry_index) < 9'(TABLE_DEPTH);
        pm_we  = request.valid && request.data.func == crtm_pkg::FUNC_PMAP &&
                 7'(request.data.entry_index) < 7'(PMAP_DEPTH);
      end
      crtm_pkg::S_TLAT: begin
        div_start = (tbl_rdata.freq != '0);
      end
      crtm_pkg::S_DIV1: begin
        div_start    = div_done;
        div_dividend = {1'b0, ent.freq};
        div_divisor  = {1'b0, div_quot[31:0]};
      end
      crtm_pkg::S_DONE: begin
        res_load = !result.valid || result.ready;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= crtm_pkg::S_IDLE;
      table_count  <= '0;
      parent_count <= '0;
      match_exact  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          crtm_pkg::REG_TABLE_COUNT:  table_count  <= cfg_data;
          crtm_pkg::REG_PARENT_COUNT: parent_count <= cfg_data[3:0];
          crtm_pkg::REG_MATCH_EXACT:  match_exact  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    case (state)
      crtm_pkg::S_IDLE: begin
        if (accept && request.data.func == crtm_pkg::FUNC_RATE) begin
          rq_hz     <= request.data.req_hz;
          cur       <= request.data.cur_cfg;
          idx       <= '0;
          pidx      <= '0;
          win_idx   <= '0;
          win_delta <= '1;
          if (count == '0) begin
            status <= crtm_pkg::ST_EMPTY;
          end else if (request.data.req_hz == '0) begin
            status <= crtm_pkg::ST_ZERO_REQ;
          end else begin
            status <= crtm_pkg::ST_OK;
          end
        end
      end
      crtm_pkg::S_TLAT: begin
        ent <= tbl_rdata;
      end
      crtm_pkg::S_DIV2: begin
        if (div_done && delta < win_delta) begin
          win_delta <= delta;
          win_idx   <= idx[IW-1:0];
        end
      end
      crtm_pkg::S_NEXT: begin
        if (idx_next != count) begin
          idx <= idx_next;
        end
      end
      crtm_pkg::S_CHK: begin
        if (match_exact && win_delta != '0) begin
          status <= crtm_pkg::ST_NOT_EXACT;
        end
        idx <= CW'(win_idx);
      end
      crtm_pkg::S_BLAT: begin
        ent <= tbl_rdata;
        if (tbl_rdata.freq == '0) begin
          status <= crtm_pkg::ST_ZERO_FREQ;
        end else if (pcount == '0) begin
          status <= crtm_pkg::ST_UNMAPPED;
        end
      end
      crtm_pkg::S_PCMP: begin
        if (pm_rdata.id == ent.parent) begin
          sel    <= pm_rdata.sel;
          status <= (ent.prediv == '0) ? crtm_pkg::ST_ZERO_PREDIV : crtm_pkg::ST_OK;
        end else if (pidx_next == pcount) begin
          status <= crtm_pkg::ST_UNMAPPED;
        end else begin
          pidx <= pidx_next;
        end
      end
      default: ;
    endcase
  end

  // result word
  assign hid_full = ent.prediv - 6'd1;
  assign d_val    = (ent.n > ent.m) ? (ent.n - ent.m) : '0;

  always_comb begin
    cfg_val = cur;
    cfg_val[crtm_pkg::SEL_LSB +: crtm_pkg::SEL_W] = sel;
    cfg_val[crtm_pkg::HID_W-1:0] = hid_full[crtm_pkg::HID_W-1:0];
    res_next = '0;
    res_next.status = status;
    if (status == crtm_pkg::ST_OK) begin
      res_next.best_index = 4'(win_idx);
      res_next.src_hz     = ent.freq;
      res_next.cfg_word   = cfg_val;
      res_next.m_out      = ent.m;
      res_next.n_out      = ent.n;
      res_next.d_out      = d_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.data <= res_next;
    end
  end

endmodule

[tb/tb_top.sv]
// testbench for the clock rate table match block: self-checking scoreboard and channel drivers
`timescale 1ns / 100ps

localparam int TABLE_SLOTS = 16;
localparam int PMAP_SLOTS  = 8;

class rate_match_scoreboard;
  logic [4:0]       table_count;
  logic [3:0]       parent_count;
  logic             match_exact;
  crtm_pkg::entry_t table_mirror[TABLE_SLOTS];
  crtm_pkg::pmap_t  pmap_mirror[PMAP_SLOTS];
  crtm_pkg::res_t   expected_results[$];
  int unsigned      errors;

  function new();
    table_count  = '0;
    parent_count = '0;
    match_exact  = 1'b0;
    errors       = 0;
    foreach (table_mirror[i]) table_mirror[i] = '0;
    foreach (pmap_mirror[i]) pmap_mirror[i] = '0;
  endfunction

  function void set_config(logic [crtm_pkg::CFG_AW-1:0] index,
                           logic [crtm_pkg::CFG_DW-1:0] value);
    case (index)
      crtm_pkg::REG_TABLE_COUNT:  table_count = value;
      crtm_pkg::REG_PARENT_COUNT: parent_count = value[3:0];
      crtm_pkg::REG_MATCH_EXACT:  match_exact = value[0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return expected_results.size();
  endfunction

  function crtm_pkg::res_t match_rate(crtm_pkg::req_t r);
    crtm_pkg::res_t   o;
    int unsigned      used;
    int unsigned      mapped;
    int unsigned      best;
    logic [31:0]      win_delta;
    logic [31:0]      delta;
    logic [63:0]      div;
    logic [63:0]      quot;
    logic [5:0]       hid;
    logic [2:0]       sel;
    logic [31:0]      cfg;
    crtm_pkg::entry_t e;
    bit               found;
    o = '0;
    used = (table_count > TABLE_SLOTS) ? TABLE_SLOTS : table_count;
    mapped = (parent_count > PMAP_SLOTS) ? PMAP_SLOTS : parent_count;
    if (used == 0) begin
      o.status = crtm_pkg::ST_EMPTY;
      return o;
    end
    if (r.req_hz == 0) begin
      o.status = crtm_pkg::ST_ZERO_REQ;
      return o;
    end
    win_delta = '1;
    best = 0;
    for (int i = 0; i < used; i++) begin
      if (table_mirror[i].freq != 0) begin
        div = ({32'd0, table_mirror[i].freq} + {32'd0, r.req_hz} - 64'd1) / {32'd0, r.req_hz};
        quot = {32'd0, table_mirror[i].freq} / div;
        delta = r.req_hz - quot[31:0];
        if (delta < win_delta) begin
          win_delta = delta;
          best = i;
        end
      end
    end
    if (match_exact && win_delta != 0) begin
      o.status = crtm_pkg::ST_NOT_EXACT;
      return o;
    end
    e = table_mirror[best];
    if (e.freq == 0) begin
      o.status = crtm_pkg::ST_ZERO_FREQ;
      return o;
    end
    found = 1'b0;
    sel = '0;
    for (int i = 0; i < mapped && !found; i++) begin
      if (pmap_mirror[i].id == e.parent) begin
        sel = pmap_mirror[i].sel;
        found = 1'b1;
      end
    end
    if (!found) begin
      o.status = crtm_pkg::ST_UNMAPPED;
      return o;
    end
    if (e.prediv == 0) begin
      o.status = crtm_pkg::ST_ZERO_PREDIV;
      return o;
    end
    hid = e.prediv - 6'd1;
    cfg = r.cur_cfg;
    cfg[crtm_pkg::SEL_LSB +: crtm_pkg::SEL_W] = sel;
    cfg[crtm_pkg::HID_W-1:0] = hid[crtm_pkg::HID_W-1:0];
    o.status     = crtm_pkg::ST_OK;
    o.best_index = best[3:0];
    o.src_hz     = e.freq;
    o.cfg_word   = cfg;
    o.m_out      = e.m;
    o.n_out      = e.n;
    o.d_out      = (e.n > e.m) ? e.n - e.m : '0;
    return o;
  endfunction

  function void note_request(crtm_pkg::req_t r);
    case (r.func)
      crtm_pkg::FUNC_TABLE: begin
        table_mirror[r.entry_index] = '{freq: r.freq_hz, parent: r.parent_ref,
                                        prediv: r.pre_div, m: r.m_value, n: r.n_value};
      end
      crtm_pkg::FUNC_PMAP: begin
        if (r.entry_index < PMAP_SLOTS)
          pmap_mirror[r.entry_index] = '{id: r.parent_ref, sel: r.source_select};
      end
      crtm_pkg::FUNC_RATE: expected_results.push_back(match_rate(r));
      default: ;
    endcase
  endfunction

  function void compare(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(crtm_pkg::res_t got);
    crtm_pkg::res_t want;
    if (expected_results.size() == 0) begin
      $display("%0t result with none expected, got status %0h", $time, got.status);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    compare("status", 32'(want.status), 32'(got.status));
    compare("best_index", 32'(want.best_index), 32'(got.best_index));
    compare("src_hz", want.src_hz, got.src_hz);
    compare("cfg_word", want.cfg_word, got.cfg_word);
    compare("m_out", 32'(want.m_out), 32'(got.m_out));
    compare("n_out", 32'(want.n_out), 32'(got.n_out));
    compare("d_out", 32'(want.d_out), 32'(got.d_out));
  endfunction
endclass

module tb_top;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned LOAD_SETTLE = 20;
  localparam int unsigned RATE_SETTLE = 1300;
  localparam int unsigned PHASE_ITEMS = 165;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [crtm_pkg::CFG_AW-1:0]   cfg_index;
  logic [crtm_pkg::CFG_DW-1:0]   cfg_data;
  logic [31:0]                   freq_shadow[TABLE_SLOTS];
  bit                            tx_burst = 1'b0;
  bit                            rx_burst = 1'b0;
  int unsigned                   rx_wait;
  int unsigned                   cycles = 0;
  rate_match_scoreboard          sb = new();

  crtm_req_if request_ch();
  crtm_res_if result_ch();

  clock_rate_table_match u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request_ch),
    .result    (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(inout bit burst);
    if ($urandom_range(0, 99) < 4) burst = !burst;
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  always @(posedge clk) begin
    if (!rst && request_ch.valid && request_ch.ready) sb.note_request(request_ch.data);
  end

  always @(posedge clk) begin : result_side
    int unsigned g;
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_wait <= draw_gap(rx_burst);
    end else if (result_ch.valid && result_ch.ready) begin
      sb.check_result(result_ch.data);
      g = draw_gap(rx_burst);
      rx_wait <= g;
      result_ch.ready <= (g == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      result_ch.ready <= (rx_wait == 1);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  function automatic crtm_pkg::req_t random_fields();
    crtm_pkg::req_t r;
    r.func          = 2'($urandom_range(0, 3));
    r.entry_index   = 4'($urandom);
    r.freq_hz       = $urandom;
    r.parent_ref    = 8'($urandom);
    r.pre_div       = 6'($urandom);
    r.m_value       = 16'($urandom);
    r.n_value       = 16'($urandom);
    r.source_select = 3'($urandom);
    r.req_hz        = $urandom;
    r.cur_cfg       = $urandom;
    return r;
  endfunction

  task automatic send_request(input crtm_pkg::req_t item);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap != 0) begin
      request_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_ch.valid <= 1'b1;
    request_ch.data  <= item;
    do @(posedge clk); while (!request_ch.ready);
  endtask

  task automatic load_entry(input int unsigned idx, input logic [31:0] freq,
                            input logic [7:0] parent, input logic [5:0] prediv,
                            input logic [15:0] m, input logic [15:0] n);
    crtm_pkg::req_t item;
    item = random_fields();
    item.func        = crtm_pkg::FUNC_TABLE;
    item.entry_index = idx[3:0];
    item.freq_hz     = freq;
    item.parent_ref  = parent;
    item.pre_div     = prediv;
    item.m_value     = m;
    item.n_value     = n;
    freq_shadow[idx[3:0]] = freq;
    send_request(item);
  endtask

  task automatic load_parent(input int unsigned idx, input logic [7:0] id,
                             input logic [2:0] sel);
    crtm_pkg::req_t item;
    item = random_fields();
    item.func          = crtm_pkg::FUNC_PMAP;
    item.entry_index   = idx[3:0];
    item.parent_ref    = id;
    item.source_select = sel;
    send_request(item);
  endtask

  task automatic ask_rate(input logic [31:0] rate, input logic [31:0] cur);
    crtm_pkg::req_t item;
    item = random_fields();
    item.func    = crtm_pkg::FUNC_RATE;
    item.req_hz  = rate;
    item.cur_cfg = cur;
    send_request(item);
  endtask

  task automatic send_unused_func();
    crtm_pkg::req_t item;
    item = random_fields();
    item.func = FUNC_UNUSED;
    send_request(item);
  endtask

  task automatic write_config(input logic [crtm_pkg::CFG_DW-1:0] tc,
                              input logic [crtm_pkg::CFG_DW-1:0] pc,
                              input logic [crtm_pkg::CFG_DW-1:0] me);
    cfg_we    <= 1'b1;
    cfg_index <= crtm_pkg::REG_TABLE_COUNT;
    cfg_data  <= tc;
    @(posedge clk);
    cfg_index <= crtm_pkg::REG_PARENT_COUNT;
    cfg_data  <= pc;
    @(posedge clk);
    cfg_index <= crtm_pkg::REG_MATCH_EXACT;
    cfg_data  <= me;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(crtm_pkg::REG_TABLE_COUNT, tc);
    sb.set_config(crtm_pkg::REG_PARENT_COUNT, pc);
    sb.set_config(crtm_pkg::REG_MATCH_EXACT, me);
  endtask

  // the edge after the last request lets the monitor note it first
  task automatic drain(input int unsigned settle);
    request_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic random_item(input int unsigned used);
    int unsigned p;
    int unsigned idx;
    int unsigned k;
    logic [31:0] freq;
    logic [31:0] rate;
    logic [7:0]  parent;
    logic [5:0]  prediv;
    logic [15:0] m;
    p = $urandom_range(0, 99);
    parent = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
    if (p < 22) begin
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, used - 1);
      case ($urandom_range(0, 9))
        0: freq = '0;
        1: freq = '1;
        2: freq = $urandom;
        3: freq = $urandom_range(1, 1000);
        default: freq = $urandom_range(1, 4000) * 1_000_000;
      endcase
      case ($urandom_range(0, 11))
        0: prediv = '0;
        1: prediv = 6'($urandom_range(33, 63));
        default: prediv = 6'($urandom_range(1, 32));
      endcase
      m = 16'($urandom);
      load_entry(idx, freq, parent, prediv, m,
                 ($urandom_range(0, 9) == 0) ? m : 16'($urandom));
    end else if (p < 30) begin
      load_parent($urandom_range(0, 15), parent, 3'($urandom));
    end else if (p < 32) begin
      send_unused_func();
    end else begin
      // mostly rates that a table entry can hit exactly
      case ($urandom_range(0, 19))
        0: rate = '0;
        1: rate = '1;
        2, 3, 4, 5: rate = $urandom;
        6, 7, 8: rate = $urandom_range(1, 1000);
        default: begin
          k = $urandom_range(1, 10);
          rate = freq_shadow[$urandom_range(0, used - 1)] / k;
        end
      endcase
      ask_rate(rate, $urandom);
    end
  endtask

  initial begin
    logic [crtm_pkg::CFG_DW-1:0] tc;
    logic [crtm_pkg::CFG_DW-1:0] pc;
    logic [crtm_pkg::CFG_DW-1:0] me;
    int unsigned                 used;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    request_ch.valid = 1'b0;
    request_ch.data  = '0;
    foreach (freq_shadow[i]) freq_shadow[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_config(0, 0, 0);
    ask_rate(32'd1000, '1);
    send_unused_func();
    for (int i = 0; i < TABLE_SLOTS; i++)
      load_entry(i, 32'((i + 1) * 10_000_000), 8'(i % 6), 6'(i + 1),
                 16'($urandom), 16'($urandom));
    for (int i = 0; i < PMAP_SLOTS; i++) load_parent(i, 8'(i), 3'(7 - i));
    // slots beyond the map depth must not land on slot 0
    load_parent(8, 0, 5);
    load_parent(15, 0, 6);
    drain(LOAD_SETTLE);

    write_config(4, 8, 0);
    ask_rate('0, $urandom);
    load_entry(0, '0, 1, 1, '0, '0);
    load_entry(1, 100, 1, 1, 16'h0000, 16'hFFFF);
    load_entry(2, '1, 2, 32, 16'hFFFF, 16'h0000);
    load_entry(3, 300, 3, 63, 16'd7, 16'd7);
    ask_rate(100, '1);
    ask_rate('1, '0);
    ask_rate(150, $urandom);
    load_entry(3, 300, 200, 63, 16'd7, 16'd7);
    ask_rate(150, $urandom);
    load_entry(1, 100, 1, 0, '0, 16'hFFFF);
    ask_rate(100, $urandom);
    drain(LOAD_SETTLE);

    write_config(4, 8, 1);
    ask_rate(7, $urandom);
    drain(LOAD_SETTLE);
    write_config(4, 0, 0);
    ask_rate('1, $urandom);
    drain(LOAD_SETTLE);
    write_config(1, 8, 0);
    ask_rate(5, $urandom);
    drain(LOAD_SETTLE);
    write_config(1, 8, 1);
    ask_rate(5, $urandom);
    drain(LOAD_SETTLE);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin tc = 31; pc = 15; me = 0; end
        1: begin tc = 16; pc = 8;  me = 1; end
        2: begin tc = 1;  pc = 1;  me = 0; end
        default: begin
          tc = 5'($urandom_range(2, 15));
          pc = 5'($urandom_range(1, 8));
          me = 5'($urandom_range(0, 1));
        end
      endcase
      write_config(tc, pc, me);
      used = (tc > TABLE_SLOTS) ? TABLE_SLOTS : tc;
      repeat (PHASE_ITEMS) random_item(used);
      drain((ph == 5) ? RATE_SETTLE : LOAD_SETTLE);
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
